// ===== src/escape_utf8_codepoint_decoder_unit_defines.svh =====
// Assertion macros used by the checker file of the escaped UTF-8 decoder.
// No dependencies; include by bare file name.
`ifndef ESCAPE_UTF8_CODEPOINT_DECODER_UNIT_DEFINES_SVH
`define ESCAPE_UTF8_CODEPOINT_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define EUCD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eucd check failed");

// Next-cycle implication, disabled while reset is high.
`define EUCD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eucd check failed");

// Same-cycle implication that also holds across reset.
`define EUCD_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("eucd check failed");

`endif

// ===== src/eucd_pkg.sv =====
// Shared types, constants and decode helpers of the escaped UTF-8 decoder.
// No dependencies; used by the decode stage, the result buffer and the top level.
package eucd_pkg;

   localparam int unsigned CpWidth = 32;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_CONT = 3'd1;
   localparam logic [2:0] PH_ESC  = 3'd2;
   localparam logic [2:0] PH_OCT  = 3'd3;
   localparam logic [2:0] PH_HEX  = 3'd4;

   localparam logic [CpWidth-1:0] QMARK = 32'd63;
   localparam logic [7:0] BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X_LO = 8'h78;
   localparam logic [7:0] CHAR_U_LO = 8'h75;
   localparam logic [7:0] CHAR_U_UP = 8'h55;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               malformed;
      logic               last_of_run;
   } result_type;

   // Up to two results produced by one byte.
   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } decode_out_type;

   typedef struct packed {
      logic [2:0]         phase;
      logic               load_acc;
      logic [CpWidth-1:0] acc;
      logic [3:0]         left;
      logic               emit;
      logic [CpWidth-1:0] cp;
      logic               bad;
   } start_type;

   // Digit value 0..15, or 16 for a non-digit.
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [7:0] u;
      logic [7:0] d;
      u = b & 8'hDF;
      d = 8'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         d = b - 8'h30;
         return d[4:0];
      end
      if (u >= 8'h41 && u <= 8'h46) begin
         d = u - 8'h37;
         return d[4:0];
      end
      return 5'd16;
   endfunction

   function automatic logic [4:0] oct_value(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h37) return {2'b00, b[2:0]};
      return 5'd16;
   endfunction

   // Bit 8 flags a single-letter escape, bits 7:0 give its code.
   function automatic logic [8:0] simple_escape(input logic [7:0] b);
      logic [8:0] r;
      case (b)
         8'h61:   r = {1'b1, 8'd7};
         8'h62:   r = {1'b1, 8'd8};
         8'h66:   r = {1'b1, 8'd12};
         8'h6E:   r = {1'b1, 8'd10};
         8'h72:   r = {1'b1, 8'd13};
         8'h74:   r = {1'b1, 8'd9};
         8'h76:   r = {1'b1, 8'd11};
         8'h27:   r = {1'b1, 8'h27};
         8'h22:   r = {1'b1, 8'h22};
         8'h5C:   r = {1'b1, 8'h5C};
         8'h3F:   r = {1'b1, 8'h3F};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Classify a byte seen at the start of a character.
   function automatic start_type start_char(input logic [7:0] b);
      start_type s;
      s.phase    = PH_IDLE;
      s.load_acc = 1'b0;
      s.acc      = '0;
      s.left     = 4'd0;
      s.emit     = 1'b0;
      s.cp       = QMARK;
      s.bad      = 1'b0;
      if (b == BACKSLASH) begin
         s.phase = PH_ESC;
      end else if (!b[7]) begin
         s.emit = 1'b1;
         s.cp   = {24'd0, b};
      end else if (b[7:5] == 3'b110) begin
         s.load_acc = 1'b1;
         s.acc      = {27'd0, b[4:0]};
         s.left     = 4'd1;
         s.phase    = PH_CONT;
      end else if (b[7:4] == 4'b1110) begin
         s.load_acc = 1'b1;
         s.acc      = {28'd0, b[3:0]};
         s.left     = 4'd2;
         s.phase    = PH_CONT;
      end else if (b[7:3] == 5'b11110) begin
         s.load_acc = 1'b1;
         s.acc      = {29'd0, b[2:0]};
         s.left     = 4'd3;
         s.phase    = PH_CONT;
      end else begin
         s.emit = 1'b1;
         s.bad  = 1'b1;
      end
      return s;
   endfunction

   // Append one result; a third one is dropped.
   function automatic decode_out_type add_result(input decode_out_type o,
                                                 input logic [CpWidth-1:0] cp,
                                                 input logic bad);
      decode_out_type r;
      r = o;
      case (o.count)
         2'd0: begin
            r.res0.code_point = cp;
            r.res0.malformed  = bad;
            r.count           = 2'd1;
         end
         2'd1: begin
            r.res1.code_point = cp;
            r.res1.malformed  = bad;
            r.count           = 2'd2;
         end
         default: r = o;
      endcase
      return r;
   endfunction

endpackage

// ===== src/eucd_req_if.sv =====
// Input channel of the escaped UTF-8 decoder: one raw byte per transaction.
// No dependencies.
interface eucd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_stream;

   modport source (output valid, output byte_in, output end_of_stream, input ready);
   modport sink   (input valid, input byte_in, input end_of_stream, output ready);
endinterface

// ===== src/eucd_rsp_if.sv =====
// Result channel of the escaped UTF-8 decoder: one code point per transaction.
// No dependencies.
interface eucd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] code_point;
   logic        malformed;
   logic        last_of_run;

   modport source (output valid, output code_point, output malformed,
                   output last_of_run, input ready);
   modport sink   (input valid, input code_point, input malformed,
                   input last_of_run, output ready);
endinterface

// ===== src/eucd_decode.sv =====
// Decode stage: holds the decoder state and turns one registered byte into
// up to two results. Depends on eucd_pkg.
module eucd_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  logic [7:0]             item_byte,
   input  logic                   item_eos,
   input  logic                   commit,
   output eucd_pkg::decode_out_type dec
);

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [3:0]  left_ff, left_in;
   logic        limited_ff, limited_in;
   logic        badc_ff, badc_in;

   eucd_pkg::start_type      st;
   eucd_pkg::decode_out_type res;
   logic [4:0] digit;
   logic [4:0] oct_d;
   logic [3:0] left_dec;
   logic [8:0] esc;

   assign st       = eucd_pkg::start_char(item_byte);
   assign esc      = eucd_pkg::simple_escape(item_byte);
   assign left_dec = left_ff - 4'd1;
   assign oct_d    = eucd_pkg::oct_value(item_byte);
   assign digit    = (phase_ff == eucd_pkg::PH_OCT) ? oct_d
                                                    : eucd_pkg::hex_value(item_byte);

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      left_in    = left_ff;
      limited_in = limited_ff;
      badc_in    = badc_ff;
      res        = '0;

      case (phase_ff)
         eucd_pkg::PH_CONT: begin
            if (item_byte[7:6] != 2'b10) badc_in = 1'b1;
            acc_in  = {acc_ff[25:0], item_byte[5:0]};
            left_in = left_dec;
            if (left_dec == 4'd0) begin
               if (badc_in) res = eucd_pkg::add_result(res, eucd_pkg::QMARK, 1'b1);
               else         res = eucd_pkg::add_result(res, acc_in, 1'b0);
               phase_in = eucd_pkg::PH_IDLE;
               badc_in  = 1'b0;
            end
         end
         eucd_pkg::PH_ESC: begin
            if (esc[8]) begin
               res      = eucd_pkg::add_result(res, {24'd0, esc[7:0]}, 1'b0);
               phase_in = eucd_pkg::PH_IDLE;
            end else if (!oct_d[4]) begin
               acc_in     = {29'd0, item_byte[2:0]};
               left_in    = 4'd2;
               limited_in = 1'b1;
               phase_in   = eucd_pkg::PH_OCT;
            end else if (item_byte == eucd_pkg::CHAR_X_LO ||
                         item_byte == eucd_pkg::CHAR_U_LO ||
                         item_byte == eucd_pkg::CHAR_U_UP) begin
               acc_in     = '0;
               limited_in = (item_byte != eucd_pkg::CHAR_X_LO);
               left_in    = (item_byte == eucd_pkg::CHAR_U_LO) ? 4'd4 :
                            (item_byte == eucd_pkg::CHAR_U_UP) ? 4'd8 : 4'd0;
               phase_in   = eucd_pkg::PH_HEX;
            end else begin
               // unknown escape: flag it, then decode the byte afresh
               res      = eucd_pkg::add_result(res, eucd_pkg::QMARK, 1'b1);
               phase_in = st.phase;
               badc_in  = 1'b0;
               if (st.load_acc) begin
                  acc_in  = st.acc;
                  left_in = st.left;
               end
               if (st.emit) res = eucd_pkg::add_result(res, st.cp, st.bad);
            end
         end
         eucd_pkg::PH_OCT, eucd_pkg::PH_HEX: begin
            if (!digit[4]) begin
               acc_in = (phase_ff == eucd_pkg::PH_OCT) ? {acc_ff[28:0], digit[2:0]}
                                                       : {acc_ff[27:0], digit[3:0]};
               if (limited_ff) begin
                  left_in = left_dec;
                  if (left_dec == 4'd0) begin
                     res      = eucd_pkg::add_result(res, acc_in, 1'b0);
                     phase_in = eucd_pkg::PH_IDLE;
                  end
               end
            end else begin
               // non-digit ends the number and starts a new character
               res      = eucd_pkg::add_result(res, acc_ff, 1'b0);
               phase_in = st.phase;
               badc_in  = 1'b0;
               if (st.load_acc) begin
                  acc_in  = st.acc;
                  left_in = st.left;
               end
               if (st.emit) res = eucd_pkg::add_result(res, st.cp, st.bad);
            end
         end
         default: begin
            phase_in = st.phase;
            badc_in  = 1'b0;
            if (st.load_acc) begin
               acc_in  = st.acc;
               left_in = st.left;
            end
            if (st.emit) res = eucd_pkg::add_result(res, st.cp, st.bad);
         end
      endcase

      // flush whatever is pending at the end of the stream
      if (item_eos) begin
         if (phase_in == eucd_pkg::PH_CONT || phase_in == eucd_pkg::PH_ESC)
            res = eucd_pkg::add_result(res, eucd_pkg::QMARK, 1'b1);
         else if (phase_in == eucd_pkg::PH_OCT || phase_in == eucd_pkg::PH_HEX)
            res = eucd_pkg::add_result(res, acc_in, 1'b0);
         phase_in = eucd_pkg::PH_IDLE;
         badc_in  = 1'b0;
      end

      res.res0.last_of_run = (res.count == 2'd1);
      res.res1.last_of_run = (res.count == 2'd2);
      if (!item_valid) res.count = 2'd0;
   end

   assign dec = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= eucd_pkg::PH_IDLE;
         acc_ff     <= '0;
         left_ff    <= 4'd0;
         limited_ff <= 1'b0;
         badc_ff    <= 1'b0;
      end else if (commit) begin
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         left_ff    <= left_in;
         limited_ff <= limited_in;
         badc_ff    <= badc_in;
      end
   end

endmodule

// ===== src/eucd_rspq.sv =====
// Two-entry result buffer: takes up to two results per cycle from the decode
// stage while it has room, and drives the result channel. Depends on eucd_pkg and eucd_rsp_if.
module eucd_rspq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     commit,
   input  eucd_pkg::decode_out_type dec,
   output logic                     room,
   eucd_rsp_if.source               rsp_chan
);

   eucd_pkg::result_type slot0_ff, slot0_in;
   eucd_pkg::result_type slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;
   logic [1:0] kept;
   logic       pop;
   eucd_pkg::result_type kept0;

   // room is judged without the pop, so it does not depend combinationally on rsp ready
   assign room  = ({1'b0, count_ff} + {1'b0, dec.count}) <= 3'd2;
   assign pop   = (count_ff != 2'd0) && rsp_chan.ready;
   assign kept  = count_ff - {1'b0, pop};
   assign kept0 = pop ? slot1_ff : slot0_ff;

   always_comb begin
      case (kept)
         2'd0: begin
            slot0_in = dec.res0;
            slot1_in = dec.res1;
         end
         2'd1: begin
            slot0_in = kept0;
            slot1_in = dec.res0;
         end
         default: begin
            slot0_in = slot0_ff;
            slot1_in = slot1_ff;
         end
      endcase
      count_in = kept + (commit ? dec.count : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= 2'd0;
      else       count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_chan.valid       = (count_ff != 2'd0);
   assign rsp_chan.code_point  = slot0_ff.code_point;
   assign rsp_chan.malformed   = slot0_ff.malformed;
   assign rsp_chan.last_of_run = slot0_ff.last_of_run;

endmodule

// ===== src/escape_utf8_codepoint_decoder_unit.sv =====
// Escaped UTF-8 decoder: one byte per req transaction in, one code point per
// rsp transaction out. A byte is taken every cycle while the result buffer has
// room. It is held in the input register, where the decode logic resolves it
// against the decoder state, and its results are written into the result
// buffer, which drives rsp. A byte gives zero, one or two results; the
// two-entry result buffer sets the rate, so a byte that yields two results
// while a result is still waiting holds the input until that result has left,
// and a stalled rsp side stops the input once the buffer is full.
// Depends on eucd_pkg, eucd_req_if, eucd_rsp_if, eucd_decode and eucd_rspq.
module escape_utf8_codepoint_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   eucd_req_if.sink   req_chan,
   eucd_rsp_if.source rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;
   logic       commit;
   logic       room;
   logic       req_fire;
   eucd_pkg::decode_out_type dec;

   assign commit         = in_valid_ff && room;
   assign req_chan.ready = !in_valid_ff || commit;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_fire || (in_valid_ff && !commit);

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_chan.byte_in;
         in_eos_ff  <= req_chan.end_of_stream;
      end
   end

   eucd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item_byte  (in_byte_ff),
      .item_eos   (in_eos_ff),
      .commit     (commit),
      .dec        (dec)
   );

   eucd_rspq u_rspq (
      .clock    (clock),
      .reset    (reset),
      .commit   (commit),
      .dec      (dec),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== src/eucd_chk.sv =====
// Port-level checks of the escaped UTF-8 decoder, bound to the top level.
// Depends on escape_utf8_codepoint_decoder_unit_defines.svh.
`include "escape_utf8_codepoint_decoder_unit_defines.svh"

module eucd_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_code_point,
   input logic        rsp_malformed,
   input logic        rsp_last_of_run
);

   // a stalled result transaction holds
   `EUCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_code_point) && $stable(rsp_malformed) && $stable(rsp_last_of_run))

   // every malformed result carries the replacement character
   `EUCD_ASSERT_NOW(a_bad_is_qmark, clock, reset, rsp_valid && rsp_malformed, rsp_code_point == 32'd63)

   // with an empty result buffer the input side never stalls
   `EUCD_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // reset empties the result buffer
   `EUCD_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) && !reset, !rsp_valid)

endmodule

bind escape_utf8_codepoint_decoder_unit eucd_chk u_eucd_chk (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_code_point  (rsp_chan.code_point),
   .rsp_malformed   (rsp_chan.malformed),
   .rsp_last_of_run (rsp_chan.last_of_run)
);
